/* src/hppf_pkg.sv */
`timescale 1ns / 1ps

package hppf_pkg;

	// Frame layout, byte offsets from the first byte of the Ethernet header
	localparam int PAYLOAD_START    = 54;
	localparam int ETH_TYPE_HI_POS  = 12;
	localparam int ETH_TYPE_LO_POS  = 13;
	localparam int IP_PROTO_POS     = 23;
	localparam int TCP_DPORT_HI_POS = 36;
	localparam int TCP_DPORT_LO_POS = 37;
	localparam int POS_FLOOR        = 127;

	localparam logic [7:0] ETH_TYPE_HI = 8'h08;
	localparam logic [7:0] ETH_TYPE_LO = 8'h00;
	localparam logic [7:0] PROTO_TCP   = 8'd6;

	// Defaults
	localparam int SCAN_WINDOW_DEF = 32;
	localparam int MIN_PAYLOAD_DEF = 64;
	localparam int QUEUE_DEPTH     = 4;
	localparam int RESULT_DEPTH    = 2;

	// Configuration map
	localparam logic REG_PATTERN = 1'b0;
	localparam logic REG_PORT    = 1'b1;

	localparam logic [31:0] PATTERN_RESET = 32'h666C_6173;
	localparam logic [15:0] PORT_RESET    = 16'd443;

	// Per-byte classification handed from the front to the back
	typedef struct packed {
		logic hdr_ok;
		logic pat_hit;
		logic len_ok;
		logic last;
	} byte_class_t;

endpackage

/* src/hppf_fifo.sv */
`timescale 1ns / 1ps

module hppf_fifo #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/hppf_front.sv */
`timescale 1ns / 1ps

module hppf_front import hppf_pkg::*; #(
	parameter int SCAN_WINDOW = SCAN_WINDOW_DEF,
	parameter int MIN_PAYLOAD = MIN_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	input  logic [31:0] match_pattern,
	input  logic [15:0] watched_port,
	output byte_class_t cls
);

	localparam int MIN_FRAME = PAYLOAD_START + MIN_PAYLOAD;
	localparam int POS_CAP   = (MIN_FRAME > POS_FLOOR) ? MIN_FRAME : POS_FLOOR;
	localparam int POS_W     = $clog2(POS_CAP + 1);
	localparam int WIN_LO    = PAYLOAD_START + 3;
	localparam int WIN_HI    = WIN_LO + SCAN_WINDOW;

	logic [POS_W-1:0] pos_q;
	logic [23:0]      recent_q;
	logic [31:0]      word;
	logic             hdr_ok;

	assign word = {recent_q, frame_byte};

	always_comb begin
		hdr_ok = 1'b1;
		if (pos_q == POS_W'(ETH_TYPE_HI_POS))  hdr_ok = (frame_byte == ETH_TYPE_HI);
		if (pos_q == POS_W'(ETH_TYPE_LO_POS))  hdr_ok = (frame_byte == ETH_TYPE_LO);
		if (pos_q == POS_W'(IP_PROTO_POS))     hdr_ok = (frame_byte == PROTO_TCP);
		if (pos_q == POS_W'(TCP_DPORT_HI_POS)) hdr_ok = (frame_byte == watched_port[15:8]);
		if (pos_q == POS_W'(TCP_DPORT_LO_POS)) hdr_ok = (frame_byte == watched_port[7:0]);
	end

	always_comb begin
		cls.hdr_ok  = hdr_ok;
		// pattern ends at this byte, so it starts three bytes back
		cls.pat_hit = (pos_q >= POS_W'(WIN_LO)) && (pos_q < POS_W'(WIN_HI))
			&& (word == match_pattern);
		cls.len_ok  = (pos_q >= POS_W'(MIN_FRAME - 1));
		cls.last    = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			recent_q <= '0;
		end else if (take) begin
			if (frame_end) begin
				pos_q    <= '0;
				recent_q <= '0;
			end else begin
				recent_q <= word[23:0];
				if (pos_q < POS_W'(POS_CAP)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

/* src/hppf_back.sv */
`timescale 1ns / 1ps

module hppf_back import hppf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  byte_class_t q_item,
	output logic        q_pop,
	input  logic        res_full,
	output logic        res_push,
	output logic        res_drop
);

	logic hdr_ok_q;
	logic pat_seen_q;
	logic hdr_acc;
	logic pat_acc;

	assign hdr_acc  = hdr_ok_q && q_item.hdr_ok;
	assign pat_acc  = pat_seen_q || q_item.pat_hit;
	// hold a frame's last byte until the result queue has room
	assign q_pop    = !q_empty && (!q_item.last || !res_full);
	assign res_push = q_pop && q_item.last;
	assign res_drop = hdr_acc && pat_acc && q_item.len_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_ok_q   <= 1'b1;
			pat_seen_q <= 1'b0;
		end else if (q_pop) begin
			if (q_item.last) begin
				hdr_ok_q   <= 1'b1;
				pat_seen_q <= 1'b0;
			end else begin
				hdr_ok_q   <= hdr_acc;
				pat_seen_q <= pat_acc;
			end
		end
	end

endmodule

/* src/https_payload_pattern_filter_core.sv */
`timescale 1ns / 1ps
// HTTPS payload pattern filter.
// Input channel: one Ethernet frame byte per request (frame_byte, frame_end
// marking the last byte), accepted on a clock edge with push high and full low.
// Result channel: one drop_frame verdict per frame, given for its last byte;
// the oldest verdict sits on drop_frame while empty is low and leaves on an
// edge with pop high. Drop means: ethertype 0x0800, IP protocol 6, TCP
// destination port equal to watched_port, frame of at least 54 + MIN_PAYLOAD
// bytes, and match_pattern starting within the first SCAN_WINDOW payload bytes.
// Configuration: APB write at byte address 0 (match_pattern) or 4
// (watched_port); registers read back on prdata, pready always high.
// Throughput is one byte per cycle while full is low. The front classifies
// each byte at acceptance and the back folds the classifications into a
// verdict one per cycle unless a last byte waits for result queue room.
// If the receiver stalls, verdicts collect in a two-entry result queue, then
// the four-entry byte queue fills and full rises. Reset clears both queues
// and the frame state and loads the default pattern "flas" and port 443.
module https_payload_pattern_filter_core import hppf_pkg::*; #(
	parameter int SCAN_WINDOW = SCAN_WINDOW_DEF,
	parameter int MIN_PAYLOAD = MIN_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	input  logic        pop,
	output logic        empty,
	output logic        drop_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] match_pattern_q;
	logic [15:0] watched_port_q;
	logic        cfg_wr;
	logic        take;
	byte_class_t cls;
	byte_class_t q_item;
	logic        q_empty;
	logic        q_pop;
	logic        res_full;
	logic        res_push;
	logic        res_drop;

	// Configuration registers; paddr[1:0] is the byte lane and ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pattern_q <= PATTERN_RESET;
			watched_port_q  <= PORT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PATTERN: match_pattern_q <= pwdata;
				REG_PORT:    watched_port_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PATTERN: prdata = match_pattern_q;
			REG_PORT:    prdata = {16'd0, watched_port_q};
			default:     prdata = '0;
		endcase
	end

	// Front: classify each accepted byte
	assign take = push && !full;

	hppf_front #(
		.SCAN_WINDOW(SCAN_WINDOW),
		.MIN_PAYLOAD(MIN_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.match_pattern(match_pattern_q),
		.watched_port (watched_port_q),
		.cls          (cls)
	);

	// Decoupling queue between front and back
	hppf_fifo #(
		.WIDTH($bits(byte_class_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_byte_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_data(cls),
		.full     (full),
		.pop      (q_pop),
		.pop_data (q_item),
		.empty    (q_empty)
	);

	// Back: fold classifications into the frame verdict
	hppf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_drop(res_drop)
	);

	// Result queue keeps verdicts while the receiver stalls
	hppf_fifo #(
		.WIDTH(1),
		.DEPTH(RESULT_DEPTH)
	) u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res_drop),
		.full     (res_full),
		.pop      (pop),
		.pop_data (drop_frame),
		.empty    (empty)
	);

endmodule

/* test/hppf_verdict_checker.sv */
`timescale 1ns / 1ps

// Watches the byte, verdict and register channels. Every accepted byte request
// advances a private model of the frame scan; a last byte queues the verdict
// that must come out next on the result side.
module hppf_verdict_checker import hppf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	input  logic        pop,
	input  logic        empty,
	input  logic        drop_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          verdicts_waiting,
	output int          verdicts_checked,
	output int          drops_checked
);

	localparam int MIN_FRAME  = PAYLOAD_START + MIN_PAYLOAD_DEF;
	localparam int POS_CAP    = (MIN_FRAME > POS_FLOOR) ? MIN_FRAME : POS_FLOOR;
	localparam int SCAN_FIRST = PAYLOAD_START + 3;

	logic [31:0] pattern_reg;
	logic [15:0] port_reg;
	int          position;
	logic        headers_ok;
	logic [23:0] last_three;
	logic        pattern_hit;
	logic        expected_drop;
	logic        drop_q[$];

	function automatic void clear_frame();
		position    = 0;
		headers_ok  = 1'b1;
		last_three  = '0;
		pattern_hit = 1'b0;
	endfunction

	function automatic void fold_byte(logic [7:0] b, logic last);
		logic [31:0] window;
		logic        byte_ok;
		window = {last_three, b};
		case (position)
			ETH_TYPE_HI_POS:  byte_ok = (b == ETH_TYPE_HI);
			ETH_TYPE_LO_POS:  byte_ok = (b == ETH_TYPE_LO);
			IP_PROTO_POS:     byte_ok = (b == PROTO_TCP);
			TCP_DPORT_HI_POS: byte_ok = (b == port_reg[15:8]);
			TCP_DPORT_LO_POS: byte_ok = (b == port_reg[7:0]);
			default:          byte_ok = 1'b1;
		endcase
		if (!byte_ok)
			headers_ok = 1'b0;
		// the window ends on this byte, so the pattern starts three bytes back
		if (position >= SCAN_FIRST && position < SCAN_FIRST + SCAN_WINDOW_DEF &&
				window == pattern_reg)
			pattern_hit = 1'b1;
		last_three = window[23:0];
		if (last) begin
			drop_q.push_back(headers_ok && pattern_hit && (position + 1 >= MIN_FRAME));
			clear_frame();
		end else if (position < POS_CAP) begin
			position++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_reg = PATTERN_RESET;
			port_reg = PORT_RESET;
			clear_frame();
			drop_q.delete();
			mismatch_count = 0;
			verdicts_waiting = 0;
			verdicts_checked = 0;
			drops_checked = 0;
		end else begin
			if (pop && !empty) begin
				if (drop_q.size() == 0) begin
					$error("drop_frame: verdict %0b popped with none expected", drop_frame);
					mismatch_count++;
				end else begin
					expected_drop = drop_q.pop_front();
					if (drop_frame !== expected_drop) begin
						$error("drop_frame mismatch: expected %0b, actual %0b",
							expected_drop, drop_frame);
						mismatch_count++;
					end
					verdicts_checked++;
					if (expected_drop)
						drops_checked++;
				end
			end
			if (push && !full)
				fold_byte(frame_byte, frame_end);
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_PATTERN: pattern_reg = pwdata;
					REG_PORT:    port_reg = pwdata[15:0];
					default:     ;
				endcase
			end
			verdicts_waiting = drop_q.size();
		end
	end

endmodule

/* test/https_payload_pattern_filter_core_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the payload pattern filter. The checker beside the
// block does all prediction; this module only shapes traffic on the byte,
// verdict and register channels and reports the outcome.
module https_payload_pattern_filter_core_tb;
	import hppf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int BYTE_TARGET  = 1850;
	localparam int FRAME_TARGET = 12;
	localparam int PHASES       = 6;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MIN_FRAME    = PAYLOAD_START + MIN_PAYLOAD_DEF;
	localparam int NO_PATTERN   = -1000;

	// which header byte, if any, gets corrupted in a generated frame
	typedef enum int {
		HDR_INTACT,
		BAD_TYPE_HI,
		BAD_TYPE_LO,
		BAD_PROTO,
		BAD_PORT_HI,
		BAD_PORT_LO
	} hdr_fault_e;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  frame_byte;
	logic        frame_end;
	logic        pop;
	logic        empty;
	logic        drop_frame;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int verdicts_waiting;
	int verdicts_checked;
	int drops_checked;

	// mirror of the registers, used only to build frames that can match
	logic [31:0] pattern_mirror;
	logic [15:0] port_mirror;

	bit send_steady;
	bit pop_steady;
	int holds_asked;
	int stall;
	int holds_done;
	int bytes_sent;
	int frames_sent;
	int settings_used;
	int cycle_count;

	https_payload_pattern_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.pop        (pop),
		.empty      (empty),
		.drop_frame (drop_frame),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	hppf_verdict_checker verdicts (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.frame_byte       (frame_byte),
		.frame_end        (frame_end),
		.pop              (pop),
		.empty            (empty),
		.drop_frame       (drop_frame),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.mismatch_count   (mismatch_count),
		.verdicts_waiting (verdicts_waiting),
		.verdicts_checked (verdicts_checked),
		.drops_checked    (drops_checked)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a hung handshake must not stall the run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts still due",
				cycle_count, verdicts_waiting);
			$display("Mismatches found");
			$finish;
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones; none when steady.
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Build one frame and offer it byte by byte. The header fields and the
	// pattern are laid over random content; fill, when given, replaces it.
	task automatic send_frame(input int len, input bit with_hdr, input int pat_off,
			input hdr_fault_e fault, input int fill = -1);
		logic [7:0] bytes [0:255];
		int         at;
		int         gap;
		for (int i = 0; i < 256; i++)
			bytes[i] = (fill >= 0) ? fill[7:0] : 8'($urandom_range(0, 255));
		if (with_hdr) begin
			bytes[ETH_TYPE_HI_POS]  = ETH_TYPE_HI;
			bytes[ETH_TYPE_LO_POS]  = ETH_TYPE_LO;
			bytes[IP_PROTO_POS]     = PROTO_TCP;
			bytes[TCP_DPORT_HI_POS] = port_mirror[15:8];
			bytes[TCP_DPORT_LO_POS] = port_mirror[7:0];
		end
		if (pat_off != NO_PATTERN) begin
			for (int k = 0; k < 4; k++)
				bytes[PAYLOAD_START + pat_off + k] = pattern_mirror[31 - 8 * k -: 8];
		end
		case (fault)
			BAD_TYPE_HI: at = ETH_TYPE_HI_POS;
			BAD_TYPE_LO: at = ETH_TYPE_LO_POS;
			BAD_PROTO:   at = IP_PROTO_POS;
			BAD_PORT_HI: at = TCP_DPORT_HI_POS;
			BAD_PORT_LO: at = TCP_DPORT_LO_POS;
			default:     at = -1;
		endcase
		if (at >= 0)
			bytes[at] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++) begin
			// hold the request until the block takes it
			push <= 1'b1;
			frame_byte <= bytes[i];
			frame_end <= (i == len - 1);
			@(posedge clk);
			while (full)
				@(posedge clk);
			bytes_sent++;
			@(negedge clk);
			gap = pick_gap(send_steady);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		frames_sent++;
	endtask

	// Stop sending, wait for every verdict, then let the byte queue run dry.
	task automatic drain();
		push <= 1'b0;
		while (verdicts_waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// return to idle, so a following write starts in a fresh step
		@(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] pattern, input logic [15:0] port);
		drain();
		write_reg({REG_PATTERN, 2'b00}, pattern);
		write_reg({REG_PORT, 2'b00}, {16'h0000, port});
		pattern_mirror = pattern;
		port_mirror = port;
		settings_used++;
	endtask

	// Receiver: random stalls, occasional steady popping, and a long hold-off
	// whenever the stimulus asks for one.
	initial begin
		pop = 1'b0;
		pop_steady = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (holds_done < holds_asked) begin
				pop <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end else begin
				if ($urandom_range(0, 199) == 0)
					pop_steady = !pop_steady;
				stall = pick_gap(pop_steady);
				if (stall == 0) begin
					pop <= 1'b1;
					@(negedge clk);
				end else begin
					pop <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
		end
	end

	initial begin
		int          kind;
		int          phase_frames;
		logic [15:0] rnd_port;

		arst_n = 1'b0;
		push = 1'b0;
		frame_byte = '0;
		frame_end = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pattern_mirror = PATTERN_RESET;
		port_mirror = PORT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames on the reset settings.
		send_steady = 1'b1;
		// single-byte frames at both byte extremes
		send_frame(1, 1'b0, NO_PATTERN, HDR_INTACT, 8'h00);
		send_frame(1, 1'b0, NO_PATTERN, HDR_INTACT, 8'hFF);
		// shortest droppable frame, pattern at the first and last allowed offset
		send_frame(MIN_FRAME, 1'b1, 0, HDR_INTACT);
		send_frame(MIN_FRAME, 1'b1, SCAN_WINDOW_DEF - 1, HDR_INTACT);
		// pattern just beyond the scan window
		send_frame(MIN_FRAME, 1'b1, SCAN_WINDOW_DEF, HDR_INTACT);
		// one byte short of the minimum length
		send_frame(MIN_FRAME - 1, 1'b1, 0, HDR_INTACT);
		// long frame: position saturates, verdict still counts
		send_frame(200, 1'b1, 7, HDR_INTACT);
		// wrong IP protocol
		send_frame(MIN_FRAME, 1'b1, 3, BAD_PROTO);
		// frame ends right after the ethertype
		send_frame(ETH_TYPE_LO_POS + 1, 1'b1, NO_PATTERN, HDR_INTACT);
		// pattern starting in the TCP header, before the payload
		send_frame(MIN_FRAME, 1'b1, -2, HDR_INTACT);

		for (int phase = 0; phase < PHASES; phase++) begin
			// pick the register setting: both extremes, random, then back to reset
			rnd_port = ($urandom_range(0, 3) == 0) ? PORT_RESET : 16'($urandom_range(0, 65535));
			case (phase)
				0:          set_config(32'h0000_0000, 16'h0000);
				1:          set_config(32'hFFFF_FFFF, 16'hFFFF);
				PHASES - 1: set_config(PATTERN_RESET, PORT_RESET);
				default:    set_config($urandom, rnd_port);
			endcase
			phase_frames = 0;
			if (phase == 1 || phase == 4) begin
				// receiver holds off while short frames keep coming, so the
				// verdict queue and then the byte queue fill and full rises
				holds_asked++;
				send_steady = 1'b1;
				repeat (8) begin
					send_frame($urandom_range(2, 12), 1'b1, NO_PATTERN, HDR_INTACT);
					phase_frames++;
				end
			end
			// spread the byte budget over the phases, a few frames at least
			while (bytes_sent < BYTE_TARGET * (phase + 1) / PHASES ||
					phase_frames < FRAME_TARGET / PHASES) begin
				send_steady = ($urandom_range(0, 4) == 0);
				kind = $urandom_range(0, 99);
				if (kind < 45) begin
					// well-formed candidate, mostly near the minimum length
					send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(128, 200)
						: $urandom_range(MIN_FRAME, MIN_FRAME + 12),
						1'b1, $urandom_range(0, SCAN_WINDOW_DEF - 1), HDR_INTACT);
				end else if (kind < 65) begin
					// near miss: bad header byte, odd length or misplaced pattern
					send_frame($urandom_range(MIN_FRAME - 8, MIN_FRAME + 20), 1'b1,
						$urandom_range(0, SCAN_WINDOW_DEF + 8) - 3,
						hdr_fault_e'($urandom_range(0, 5)));
				end else if (kind < 85) begin
					// short frame ending in or just after the headers
					send_frame($urandom_range(1, 60), 1'b1, NO_PATTERN,
						hdr_fault_e'($urandom_range(0, 5)));
				end else begin
					// plain noise
					send_frame($urandom_range(1, 150), 1'b0, NO_PATTERN, HDR_INTACT);
				end
				phase_frames++;
			end
		end

		drain();
		$display("Sent %0d frames (%0d bytes) over %0d register settings, %0d long hold-offs",
			frames_sent, bytes_sent, settings_used, holds_done);
		$display("Checked %0d verdicts, %0d of them drops, %0d mismatches",
			verdicts_checked, drops_checked, mismatch_count);
		if (mismatch_count == 0 && verdicts_waiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
